// ===== rtl/core/lae_pkg.sv =====
// Shared types, register and mode codes, and the color wheel function for
// the LED strip animation engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lae_pkg;

  localparam int unsigned PixIdxW = 5;

  localparam logic [7:0] FadeReset   = 8'd3;
  localparam logic [2:0] DimReset    = 3'd3;
  localparam logic [9:0] ChaseReset  = 10'd200;
  localparam logic [9:0] WheelReset  = 10'd400;
  localparam logic [7:0] PhaseStep   = 8'd4;
  localparam logic [7:0] LevelTop    = 8'd127;
  localparam logic [7:0] FullScale   = 8'd255;
  localparam logic [7:0] FillFull    = 8'd255;
  localparam logic [7:0] FillMid     = 8'd50;
  localparam logic [7:0] FillLow     = 8'd1;
  localparam logic [7:0] FillOff     = 8'd0;
  localparam logic [2:0] ColorSets   = 3'd6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lae_rgb_t;

  typedef enum logic [1:0] {
    REG_FADE_AMOUNT,
    REG_DIM_SHIFT,
    REG_CHASE_FRAMES,
    REG_WHEEL_FRAMES
  } lae_reg_e;

  typedef enum logic [2:0] {
    MODE_ANIMATE = 3'd0,
    MODE_DIMMED  = 3'd1,
    MODE_FULL    = 3'd2,
    MODE_MID     = 3'd3,
    MODE_LOW     = 3'd4,
    MODE_OFF     = 3'd5
  } lae_mode_e;

  typedef enum logic [1:0] {
    KIND_CHASE,
    KIND_WHEEL,
    KIND_HOLD,
    KIND_FILL
  } lae_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lae_state_e;

  typedef struct packed {
    lae_kind_e  kind;
    logic       dim;
    logic [7:0] fill;
    logic [2:0] sel;
    logic [7:0] level;
  } lae_frame_t;

  function automatic lae_rgb_t wheel_apply(logic [2:0] phase, logic [2:0] step,
                                           lae_rgb_t col);
    logic [7:0] s;
    logic [7:0] d;
    lae_rgb_t   o;
    s = {step, 5'b00000};
    d = FullScale - s;
    o = col;
    unique case (phase)
      3'd0: o.red   = s;
      3'd1: o.green = s;
      3'd2: o.red   = d;
      3'd3: o.blue  = s;
      3'd4: o.red   = s;
      3'd5: o.green = d;
      3'd6: o.red   = d;
      default: o.blue = d;
    endcase
    return o;
  endfunction

  // Bit 0 red, bit 1 green, bit 2 blue.
  function automatic logic [2:0] color_set(logic [2:0] idx);
    logic [2:0] s;
    unique case (idx)
      3'd0: s = 3'b111;
      3'd1: s = 3'b110;
      3'd2: s = 3'b100;
      3'd3: s = 3'b011;
      3'd4: s = 3'b010;
      3'd5: s = 3'b101;
      3'd6: s = 3'b001;
      default: s = 3'b111;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/led_strip_animation_engine.sv =====
// Top level of the LED strip animation engine: frame sequencer, pixel cell chain,
// output register and configuration registers. Depends on lae_pkg, lae_cell, lae_shade.
//
//   Channel   Signals                                         Direction
//   in        in_valid_i, in_ready_o, advance_mode_i          frame tick word in
//   out       out_valid_o, out_ready_i, pixel_index_o,
//             red_o, green_o, blue_o, last_pixel_o            one pixel word per beat
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i                register write
//
// A frame tick is taken only while no frame pass is running.
// The pass shifts the cell ring once per cycle while the output is not stalled,
// PIXEL_COUNT shifts in all, and ready returns once the last shift is done, so no
// new frame tick is taken before the pass has finished.
// A low out_ready_i with a full output register freezes the ring and the sequencer.
// Reset clears the frame buffer, the animation state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_animation_engine #(
  parameter int unsigned PIXEL_COUNT = 20
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       advance_mode_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [4:0]      pixel_index_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            last_pixel_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [9:0] cfg_wdata_i
);
  import lae_pkg::*;

  localparam int unsigned IW = $clog2(PIXEL_COUNT);
  localparam logic [IW-1:0] LastIdx = IW'(PIXEL_COUNT - 1);
  localparam logic [IW-1:0] CountIw = IW'(PIXEL_COUNT);

  // Configuration registers.
  logic [7:0] fade_q;
  logic [2:0] dim_q;
  logic [9:0] chase_frames_q;
  logic [9:0] wheel_frames_q;

  // Animation state.
  lae_mode_e  mode_q, mode_d;
  logic [10:0] ftime_q, ftime_d;
  logic [7:0] cphase_q, cphase_d;
  logic [7:0] ccount_q, ccount_d;
  logic [2:0] cmod_q, cmod_d;
  logic [IW-1:0] cpos_q, cpos_d;
  logic [2:0] wstep_q, wstep_d;
  logic [2:0] wphase_q, wphase_d;
  lae_rgb_t   wrgb_q, wrgb_d;

  // Frame pass state.
  lae_state_e state_q, state_d;
  lae_frame_t frame_q, frame_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] dist_q, dist_d;
  logic [2:0] wk_phase_q, wk_phase_d;
  logic [2:0] wk_step_q, wk_step_d;
  lae_rgb_t   wk_rgb_q, wk_rgb_d;

  // Output register.
  logic       ovalid_q, ovalid_d;
  lae_rgb_t   opix_q, opix_d;
  logic [IW-1:0] oidx_q, oidx_d;
  logic       olast_q, olast_d;

  logic       in_fire;
  logic       step;
  lae_rgb_t   head;
  lae_rgb_t   upd;
  lae_rgb_t   wk_next;
  lae_rgb_t   cell_q [PIXEL_COUNT];
  logic [IW+4:0] oidx_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q         <= FadeReset;
      dim_q          <= DimReset;
      chase_frames_q <= ChaseReset;
      wheel_frames_q <= WheelReset;
    end else if (cfg_we_i) begin
      unique case (lae_reg_e'(cfg_idx_i))
        REG_FADE_AMOUNT:  fade_q         <= cfg_wdata_i[7:0];
        REG_DIM_SHIFT:    dim_q          <= cfg_wdata_i[2:0];
        REG_CHASE_FRAMES: chase_frames_q <= cfg_wdata_i;
        REG_WHEEL_FRAMES: wheel_frames_q <= cfg_wdata_i;
      endcase
    end
  end

  // Sequencer: state register and next state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    step       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        step = !ovalid_q || out_ready_i;
        if (step && cnt_q == LastIdx) state_d = ST_IDLE;
      end
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Frame start: decide the kind of update and advance the animation state.
  always_comb begin
    logic [10:0] ft_n;
    logic [10:0] bound;
    logic [7:0]  cp_n;
    lae_rgb_t    wnew;
    ft_n  = ftime_q + 11'd1;
    bound = {1'b0, chase_frames_q} + {1'b0, wheel_frames_q};
    cp_n  = cphase_q + PhaseStep;
    wnew  = wheel_apply(wphase_q, wstep_q, wrgb_q);

    ftime_d  = ftime_q;
    cphase_d = cphase_q;
    ccount_d = ccount_q;
    cmod_d   = cmod_q;
    cpos_d   = cpos_q;
    wstep_d  = wstep_q;
    wphase_d = wphase_q;
    wrgb_d   = wrgb_q;

    frame_d.kind  = KIND_HOLD;
    frame_d.dim   = 1'b0;
    frame_d.fill  = FillOff;
    frame_d.sel   = color_set(cmod_q);
    frame_d.level = 8'd0;

    if (mode_q == MODE_ANIMATE || mode_q == MODE_DIMMED) begin
      frame_d.dim = (mode_q == MODE_DIMMED);
      if ({1'b0, ft_n} < {2'b00, chase_frames_q}) begin
        frame_d.kind = KIND_CHASE;
        ftime_d  = ft_n;
        cphase_d = cp_n;
        frame_d.level = (cp_n <= LevelTop) ? cp_n : FullScale - cp_n;
        if (cp_n == 8'd0) begin
          ccount_d = ccount_q + 8'd1;
          if (ccount_q == 8'hFF || cmod_q == ColorSets) begin
            cmod_d = 3'd0;
          end else begin
            cmod_d = cmod_q + 3'd1;
          end
        end
        frame_d.sel = color_set(cmod_d);
        cpos_d = (cpos_q == LastIdx) ? '0 : cpos_q + IW'(1);
      end else if (ft_n < bound) begin
        frame_d.kind = KIND_WHEEL;
        ftime_d = ft_n;
        wrgb_d  = wnew;
        wstep_d = wstep_q + 3'd1;
        if (wstep_q == 3'd7) wphase_d = wphase_q + 3'd1;
      end else begin
        ftime_d = 11'd0;
      end
    end else begin
      frame_d.kind = KIND_FILL;
      unique case (mode_q)
        MODE_FULL: frame_d.fill = FillFull;
        MODE_MID:  frame_d.fill = FillMid;
        MODE_LOW:  frame_d.fill = FillLow;
        default:   frame_d.fill = FillOff;
      endcase
    end

    mode_d = mode_q;
    if (advance_mode_i) begin
      mode_d = (mode_q >= MODE_OFF) ? MODE_ANIMATE : lae_mode_e'(mode_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ANIMATE;
      ftime_q  <= '0;
      cphase_q <= '0;
      ccount_q <= '0;
      cmod_q   <= '0;
      cpos_q   <= '0;
      wstep_q  <= '0;
      wphase_q <= '0;
      wrgb_q   <= '0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      ftime_q  <= ftime_d;
      cphase_q <= cphase_d;
      ccount_q <= ccount_d;
      cmod_q   <= cmod_d;
      cpos_q   <= cpos_d;
      wstep_q  <= wstep_d;
      wphase_q <= wphase_d;
      wrgb_q   <= wrgb_d;
    end
  end

  // Frame pass registers.
  always_comb begin
    cnt_d      = cnt_q;
    dist_d     = dist_q;
    wk_phase_d = wk_phase_q;
    wk_step_d  = wk_step_q;
    wk_rgb_d   = wk_rgb_q;
    if (in_fire) begin
      cnt_d      = '0;
      dist_d     = (cpos_d == '0) ? '0 : CountIw - cpos_d;
      wk_phase_d = wphase_q;
      wk_step_d  = wstep_q;
      wk_rgb_d   = wrgb_d;
    end else if (step) begin
      cnt_d      = cnt_q + IW'(1);
      dist_d     = (dist_q == LastIdx) ? '0 : dist_q + IW'(1);
      wk_rgb_d   = wk_next;
      wk_step_d  = wk_step_q + 3'd1;
      if (wk_step_q == 3'd7) wk_phase_d = wk_phase_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      dist_q     <= '0;
      frame_q    <= '0;
      wk_phase_q <= '0;
      wk_step_q  <= '0;
      wk_rgb_q   <= '0;
    end else begin
      cnt_q      <= cnt_d;
      dist_q     <= dist_d;
      wk_phase_q <= wk_phase_d;
      wk_step_q  <= wk_step_d;
      wk_rgb_q   <= wk_rgb_d;
      if (in_fire) frame_q <= frame_d;
    end
  end

  // Pixel ring: cell 0 is the head, the updated head enters at the tail.
  assign head = cell_q[0];

  for (genvar k = 0; k < PIXEL_COUNT; k++) begin : g_cell
    lae_rgb_t nxt;
    if (k == PIXEL_COUNT - 1) begin : g_tail
      assign nxt = upd;
    end else begin : g_mid
      assign nxt = cell_q[k+1];
    end
    lae_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .d_i     (nxt),
      .q_o     (cell_q[k])
    );
  end

  lae_shade #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .IW          (IW)
  ) u_shade (
    .frame_i     (frame_q),
    .fade_i      (fade_q),
    .dim_shift_i (dim_q),
    .pix_i       (head),
    .dist_i      (dist_q),
    .wk_phase_i  (wk_phase_q),
    .wk_step_i   (wk_step_q),
    .wk_rgb_i    (wk_rgb_q),
    .pix_o       (upd),
    .wk_rgb_o    (wk_next)
  );

  // Output register.
  always_comb begin
    ovalid_d = ovalid_q;
    opix_d   = opix_q;
    oidx_d   = oidx_q;
    olast_d  = olast_q;
    if (step) begin
      ovalid_d = 1'b1;
      opix_d   = head;
      oidx_d   = cnt_q;
      olast_d  = (cnt_q == LastIdx);
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opix_q  <= opix_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  assign oidx_ext      = {5'b00000, oidx_q};
  assign out_valid_o   = ovalid_q;
  assign pixel_index_o = oidx_ext[4:0];
  assign red_o         = opix_q.red;
  assign green_o       = opix_q.green;
  assign blue_o        = opix_q.blue;
  assign last_pixel_o  = olast_q;

endmodule

`default_nettype wire

// ===== rtl/core/lae_cell.sv =====
// One pixel cell of the circular frame buffer chain.
// Depends on lae_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module lae_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_i,
  input  wire lae_pkg::lae_rgb_t d_i,
  output lae_pkg::lae_rgb_t      q_o
);
  import lae_pkg::*;

  lae_rgb_t pix_q;
  lae_rgb_t pix_d;

  assign pix_d = shift_i ? d_i : pix_q;
  assign q_o   = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lae_shade.sv =====
// Per-pixel update: fade with chaser spots, wheel walk, hold or fill, then dimming.
// Depends on lae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lae_shade #(
  parameter int unsigned PIXEL_COUNT = 20,
  parameter int unsigned IW          = $clog2(PIXEL_COUNT)
) (
  input  wire lae_pkg::lae_frame_t frame_i,
  input  wire logic [7:0]          fade_i,
  input  wire logic [2:0]          dim_shift_i,
  input  wire lae_pkg::lae_rgb_t   pix_i,
  input  wire logic [IW-1:0]       dist_i,
  input  wire logic [2:0]          wk_phase_i,
  input  wire logic [2:0]          wk_step_i,
  input  wire lae_pkg::lae_rgb_t   wk_rgb_i,
  output lae_pkg::lae_rgb_t        pix_o,
  output lae_pkg::lae_rgb_t        wk_rgb_o
);
  import lae_pkg::*;

  localparam int unsigned Half = PIXEL_COUNT / 2;
  localparam logic [IW-1:0] Off1 = IW'(1);
  localparam logic [IW-1:0] Off2 = IW'(2);
  localparam logic [IW-1:0] Off3 = IW'(3);
  localparam logic [IW-1:0] HOff1 = IW'(Half + 1);
  localparam logic [IW-1:0] HOff2 = IW'(Half + 2);
  localparam logic [IW-1:0] HOff3 = IW'(Half + 3);

  lae_rgb_t   wcol;
  lae_rgb_t   faded;
  lae_rgb_t   base;
  logic       spot_hit;
  logic [7:0] spot_val;

  function automatic logic [7:0] fade_one(logic [7:0] v, logic [7:0] amt);
    return (v <= amt) ? 8'd0 : v - amt;
  endfunction

  always_comb begin
    wcol = wheel_apply(wk_phase_i, wk_step_i, wk_rgb_i);
    wk_rgb_o = wcol;

    faded.red   = fade_one(pix_i.red, fade_i);
    faded.green = fade_one(pix_i.green, fade_i);
    faded.blue  = fade_one(pix_i.blue, fade_i);

    spot_hit = 1'b1;
    if (dist_i == Off1 || dist_i == HOff1) begin
      spot_val = frame_i.level >> 2;
    end else if (dist_i == Off2 || dist_i == HOff2) begin
      spot_val = frame_i.level;
    end else if (dist_i == Off3 || dist_i == HOff3) begin
      spot_val = frame_i.level >> 4;
    end else begin
      spot_hit = 1'b0;
      spot_val = 8'd0;
    end

    unique case (frame_i.kind)
      KIND_CHASE: begin
        base = faded;
        if (spot_hit && frame_i.sel[0]) base.red   = spot_val;
        if (spot_hit && frame_i.sel[1]) base.green = spot_val;
        if (spot_hit && frame_i.sel[2]) base.blue  = spot_val;
      end
      KIND_WHEEL: base = wcol;
      KIND_HOLD:  base = pix_i;
      default:    base = '{red: frame_i.fill, green: frame_i.fill, blue: frame_i.fill};
    endcase

    pix_o = base;
    if (frame_i.dim) begin
      pix_o.red   = base.red >> dim_shift_i;
      pix_o.green = base.green >> dim_shift_i;
      pix_o.blue  = base.blue >> dim_shift_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lae_checker.sv =====
// Port-level checks for the LED strip animation engine, bound to the top level.
// Depends on led_strip_animation_engine for the bind target.
`timescale 1ns / 1ps
`default_nettype none

module lae_checker #(
  parameter int unsigned PIXEL_COUNT = 20
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [4:0] pixel_index_o,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic       last_pixel_o
);

  localparam logic [4:0] LastIdx = 5'(PIXEL_COUNT - 1);

  // A stalled pixel word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(pixel_index_o) && $stable(red_o) && $stable(green_o) &&
      $stable(blue_o) && $stable(last_pixel_o))
    else $error("stalled pixel word changed");

  // Only the final pixel carries the last flag.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_index_o == LastIdx)
    else $error("last flag on wrong pixel");

  // Pixels of a frame follow each other without a gap.
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_pixel_o |=>
      out_valid_o && pixel_index_o == $past(pixel_index_o) + 5'd1)
    else $error("pixel order broken");

  // While a frame tick can be taken, at most the final pixel word is still waiting.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || last_pixel_o)
    else $error("frame tick offered during a frame");

  // A taken frame tick starts a pass.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready did not drop after a frame tick");

endmodule

bind led_strip_animation_engine lae_checker #(.PIXEL_COUNT(PIXEL_COUNT)) u_lae_checker (.*);

`default_nettype wire
